// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, clocked on clk, off while rst_n is low.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ----- rtl/core/tcld_pkg.sv -----
// ----------------------------------------------------------------------------
// tcld_pkg
// Shared types, character codes, keyword table and helpers of the
// text command line decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tcld_pkg;

  localparam int unsigned LINE_LEN    = 64;
  localparam int unsigned CNT_W       = $clog2(LINE_LEN);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned NUM_KW      = 15;

  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_VT_LO = 8'd9;
  localparam logic [7:0] CHAR_VT_HI = 8'd13;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SP    = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_DOT   = 8'd46;
  localparam logic [7:0] CHAR_0     = 8'd48;
  localparam logic [7:0] CHAR_9     = 8'd57;
  localparam logic [7:0] LOWER_A    = 8'd97;
  localparam logic [7:0] LOWER_Z    = 8'd122;
  localparam logic [7:0] CASE_DIFF  = 8'd32;

  typedef enum logic [3:0] {
    KIND_UNKNOWN = 4'd0,
    KIND_PING    = 4'd1,
    KIND_GET     = 4'd2,
    KIND_SAVE    = 4'd3,
    KIND_LOAD    = 4'd4,
    KIND_RESET   = 4'd5,
    KIND_STREAM  = 4'd6,
    KIND_SET_MIN = 4'd7,
    KIND_SET_MAX = 4'd8,
    KIND_CURVE   = 4'd9,
    KIND_GAMMA   = 4'd10,
    KIND_ALPHA   = 4'd11
  } kind_e;

  typedef enum logic [1:0] {
    CURVE_LINEAR = 2'd0,
    CURVE_POWER  = 2'd1,
    CURVE_SCURVE = 2'd2
  } curve_e;

  // queue word: one stored character or the end of a line
  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
    logic       ovf;
  } tcld_word_t;

  localparam logic [3:0] KW_PING   = 4'd0;
  localparam logic [3:0] KW_GET    = 4'd1;
  localparam logic [3:0] KW_SAVE   = 4'd2;
  localparam logic [3:0] KW_LOAD   = 4'd3;
  localparam logic [3:0] KW_RESET  = 4'd4;
  localparam logic [3:0] KW_STREAM = 4'd5;
  localparam logic [3:0] KW_SET    = 4'd6;
  localparam logic [3:0] KW_MIN    = 4'd7;
  localparam logic [3:0] KW_MAX    = 4'd8;
  localparam logic [3:0] KW_CURVE  = 4'd9;
  localparam logic [3:0] KW_GAMMA  = 4'd10;
  localparam logic [3:0] KW_ALPHA  = 4'd11;
  localparam logic [3:0] KW_LINEAR = 4'd12;
  localparam logic [3:0] KW_POWER  = 4'd13;
  localparam logic [3:0] KW_SCURVE = 4'd14;

  localparam logic [31:0] SAT_POS  = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG  = 32'h8000_0000;
  localparam logic [35:0] INT_CLIP = 36'h0_8000_0000;
  localparam logic [31:0] INT_HELD = 32'h8000_0001;
  localparam logic [35:0] REAL_CLIP = 36'd3000000000;

  // keyword text, right-justified, first character highest
  function automatic logic [47:0] kw_text(input logic [3:0] k);
    unique case (k)
      KW_PING:   kw_text = 48'("PING");
      KW_GET:    kw_text = 48'("GET");
      KW_SAVE:   kw_text = 48'("SAVE");
      KW_LOAD:   kw_text = 48'("LOAD");
      KW_RESET:  kw_text = 48'("RESET");
      KW_STREAM: kw_text = 48'("STREAM");
      KW_SET:    kw_text = 48'("SET");
      KW_MIN:    kw_text = 48'("MIN");
      KW_MAX:    kw_text = 48'("MAX");
      KW_CURVE:  kw_text = 48'("CURVE");
      KW_GAMMA:  kw_text = 48'("GAMMA");
      KW_ALPHA:  kw_text = 48'("ALPHA");
      KW_LINEAR: kw_text = 48'("LINEAR");
      KW_POWER:  kw_text = 48'("POWER");
      KW_SCURVE: kw_text = 48'("SCURVE");
      default:   kw_text = '0;
    endcase
  endfunction

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    unique case (k)
      KW_GET, KW_SET, KW_MIN, KW_MAX:                    kw_len = 3'd3;
      KW_PING, KW_SAVE, KW_LOAD:                         kw_len = 3'd4;
      KW_RESET, KW_CURVE, KW_GAMMA, KW_ALPHA, KW_POWER:  kw_len = 3'd5;
      KW_STREAM, KW_LINEAR, KW_SCURVE:                   kw_len = 3'd6;
      default:                                           kw_len = 3'd0;
    endcase
  endfunction

  // character at position p, zero past the end
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
    logic [47:0] t;
    logic [2:0]  n;
    logic [2:0]  sel;
    t   = kw_text(k);
    n   = kw_len(k);
    sel = 3'(n - 3'd1 - p);
    if (p < n) kw_char = t[{sel, 3'b000} +: 8];
    else       kw_char = CHAR_NUL;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    if (c >= LOWER_A && c <= LOWER_Z) to_upper = c - CASE_DIFF;
    else                              to_upper = c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CHAR_SP) || (c == CHAR_TAB);
  endfunction

  function automatic logic is_numspace(input logic [7:0] c);
    is_numspace = (c == CHAR_SP) || (c >= CHAR_VT_LO && c <= CHAR_VT_HI);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CHAR_0) && (c <= CHAR_9);
  endfunction

  function automatic logic [31:0] apply_sign(input logic [31:0] mag, input logic neg);
    if (neg) begin
      if (mag > SAT_NEG) apply_sign = SAT_NEG;
      else               apply_sign = 32'(32'd0 - mag);
    end else begin
      if (mag > SAT_POS) apply_sign = SAT_POS;
      else               apply_sign = mag;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/text_command_line_decoder.sv -----
// ----------------------------------------------------------------------------
// text_command_line_decoder
// Decodes text command lines, one received character per word, into a
// command kind with its integer, curve and milli-unit real arguments.
// ----------------------------------------------------------------------------
// Takes one character word per clock while the queue has room, and stalls
// the input when it is full: characters go through a four-word queue to a
// parser that consumes one word per cycle, and the parser holds up only when
// a newline meets a result that is still unread in the output register. One
// result comes out per newline, registered in the output register when the
// parser pops the newline from the queue behind any earlier words; carriage
// returns and characters past LINE_LEN-1 give no work to the parser.
`default_nettype none

module text_command_line_decoder (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [7:0]         char_byte_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [3:0]         kind_o,
  output logic               has_int_arg_o,
  output logic signed [31:0] int_arg_o,
  output logic [1:0]         curve_sel_o,
  output logic               has_gamma_arg_o,
  output logic signed [31:0] real_arg_milli_o,
  output logic               line_overflow_o,
  output logic               line_empty_o
);
  import tcld_pkg::*;

  tcld_word_t  push_word;
  tcld_word_t  pop_word;
  logic        q_push;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic [31:0] int_raw;
  logic [31:0] real_raw;

  tcld_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_byte_i (char_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_word_o    (push_word)
  );

  tcld_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .word_i  (push_word),
    .full_o  (q_full),
    .valid_o (q_valid),
    .word_o  (pop_word),
    .pop_i   (q_pop)
  );

  tcld_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_word_i         (pop_word),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .has_int_arg_o    (has_int_arg_o),
    .int_arg_o        (int_raw),
    .curve_sel_o      (curve_sel_o),
    .has_gamma_arg_o  (has_gamma_arg_o),
    .real_arg_milli_o (real_raw),
    .line_overflow_o  (line_overflow_o),
    .line_empty_o     (line_empty_o)
  );

  assign int_arg_o        = $signed(int_raw);
  assign real_arg_milli_o = $signed(real_raw);

endmodule

`default_nettype wire

// ----- rtl/core/tcld_front.sv -----
// ----------------------------------------------------------------------------
// tcld_front
// Takes input words, drops carriage returns, counts the line length,
// flags overflow and forwards stored characters and line ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tcld_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire  [7:0]           char_byte_i,
  input  wire                  q_full_i,
  output logic                 q_push_o,
  output tcld_pkg::tcld_word_t q_word_o
);
  import tcld_pkg::*;

  logic [CNT_W-1:0] cnt_q;
  logic             ovf_q;
  logic             zero_q;
  logic             accept;
  logic             is_lf;
  logic             is_cr;
  logic             room;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_lf      = char_byte_i == CHAR_LF;
  assign is_cr      = char_byte_i == CHAR_CR;
  assign room       = cnt_q != CNT_W'(LINE_LEN - 1);

  // content ends at the first zero byte
  assign q_push_o = accept && !is_cr &&
                    (is_lf || (room && !zero_q && char_byte_i != CHAR_NUL));
  assign q_word_o = '{ch: char_byte_i, eol: is_lf, ovf: ovf_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      zero_q <= 1'b0;
    end else if (accept) begin
      if (is_lf) begin
        cnt_q  <= '0;
        ovf_q  <= 1'b0;
        zero_q <= 1'b0;
      end else if (!is_cr) begin
        if (room) begin
          cnt_q <= cnt_q + 1'b1;
          if (char_byte_i == CHAR_NUL) zero_q <= 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tcld_queue.sv -----
// ----------------------------------------------------------------------------
// tcld_queue
// Small first-in first-out buffer between the front and the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module tcld_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  tcld_pkg::tcld_word_t word_i,
  output logic                 full_o,
  output logic                 valid_o,
  output tcld_pkg::tcld_word_t word_o,
  input  wire                  pop_i
);
  import tcld_pkg::*;

  tcld_word_t        buf_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign word_o  = buf_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wr_ptr_q] <= word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tcld_back.sv -----
// ----------------------------------------------------------------------------
// tcld_back
// On-the-fly line parser: keyword matching, number accumulation and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcld_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  q_valid_i,
  input  tcld_pkg::tcld_word_t q_word_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic [3:0]           kind_o,
  output logic                 has_int_arg_o,
  output logic [31:0]          int_arg_o,
  output logic [1:0]           curve_sel_o,
  output logic                 has_gamma_arg_o,
  output logic [31:0]          real_arg_milli_o,
  output logic                 line_overflow_o,
  output logic                 line_empty_o
);
  import tcld_pkg::*;

  typedef enum logic [3:0] {
    PH_W1_PRE, PH_W1, PH_W2_PRE, PH_W2, PH_W3_PRE, PH_W3,
    PH_NUM_PRE, PH_NUM_INT, PH_NUM_FRAC, PH_NUM_TRAIL, PH_DONE, PH_FAIL
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [NUM_KW-1:0] cand_q, cand_d, cand_base, cand_step, ended;
  logic [2:0]        pos_q, pos_d, pos_base;
  kind_e             kind_q, kind_d;
  curve_e            curve_q, curve_d;
  logic              real_q, real_d;
  logic              opt_q, opt_d;
  logic              prenb_q, prenb_d;
  logic              neg_q, neg_d;
  logic              dig_q, dig_d;
  logic [31:0]       acc_q, acc_d;
  logic [9:0]        frac_q, frac_d;
  logic [1:0]        nf_q, nf_d;

  logic              out_valid_q;
  kind_e             out_kind_q, fin_kind;
  logic              out_has_int_q, fin_has_int;
  logic [31:0]       out_int_q, fin_int;
  logic [1:0]        out_curve_q;
  logic              out_gamma_flag_q, fin_gamma_flag;
  logic [31:0]       out_real_q, fin_real;
  logic              out_ovf_q;
  logic              out_empty_q, fin_empty;

  logic [7:0]        c, cu;
  logic [3:0]        d;
  logic              blank, start, line_end, fin_ok, stream_ok;
  logic [35:0]       int_wide, real_wide;
  logic [31:0]       acc_digit;
  logic [9:0]        frac_add;

  assign q_pop_o  = q_valid_i && (!q_word_i.eol || !out_valid_q || !out_stall_i);
  assign line_end = q_pop_o && q_word_i.eol;

  // a line end is parsed as one trailing blank
  assign c     = q_word_i.eol ? CHAR_SP : q_word_i.ch;
  assign cu    = to_upper(c);
  assign d     = c[3:0];
  assign blank = is_blank(c);
  assign start = (phase_q == PH_W1_PRE) || (phase_q == PH_W2_PRE) || (phase_q == PH_W3_PRE);

  assign cand_base = start ? '1 : cand_q;
  assign pos_base  = start ? 3'd0 : pos_q;

  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      cand_step[k] = cand_base[k] && (kw_char(4'(k), pos_base) == cu);
      ended[k]     = cand_q[k] && (kw_len(4'(k)) == pos_q);
    end
  end

  assign int_wide  = 36'(acc_q) * 36'd10 + 36'(d);
  assign real_wide = 36'(acc_q) * 36'd10 + 36'(d) * 36'd1000;
  assign acc_digit = real_q ? ((real_wide > REAL_CLIP) ? REAL_CLIP[31:0] : real_wide[31:0])
                            : ((int_wide > INT_CLIP) ? INT_HELD : int_wide[31:0]);

  always_comb begin
    unique case (nf_q)
      2'd0:    frac_add = 10'(d) * 10'd100;
      2'd1:    frac_add = 10'(d) * 10'd10;
      default: frac_add = 10'(d);
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    cand_d  = cand_q;
    pos_d   = pos_q;
    kind_d  = kind_q;
    curve_d = curve_q;
    real_d  = real_q;
    opt_d   = opt_q;
    prenb_d = prenb_q;
    neg_d   = neg_q;
    dig_d   = dig_q;
    acc_d   = acc_q;
    frac_d  = frac_q;
    nf_d    = nf_q;
    if (q_pop_o) begin
      unique case (phase_q)
        PH_W1_PRE, PH_W2_PRE, PH_W3_PRE: begin
          if (!blank) begin
            cand_d = cand_step;
            pos_d  = 3'd1;
            if (phase_q == PH_W1_PRE)      phase_d = PH_W1;
            else if (phase_q == PH_W2_PRE) phase_d = PH_W2;
            else                           phase_d = PH_W3;
          end
        end
        PH_W1, PH_W2, PH_W3: begin
          if (!blank) begin
            cand_d = cand_step;
            pos_d  = (pos_q == 3'd7) ? pos_q : pos_q + 3'd1;
          end else if (phase_q == PH_W1) begin
            phase_d = PH_DONE;
            priority if (ended[KW_PING])  kind_d = KIND_PING;
            else if (ended[KW_GET])       kind_d = KIND_GET;
            else if (ended[KW_SAVE])      kind_d = KIND_SAVE;
            else if (ended[KW_LOAD])      kind_d = KIND_LOAD;
            else if (ended[KW_RESET])     kind_d = KIND_RESET;
            else if (ended[KW_STREAM]) begin
              kind_d  = KIND_STREAM;
              phase_d = PH_NUM_PRE;
            end else if (ended[KW_SET])   phase_d = PH_W2_PRE;
            else                          phase_d = PH_FAIL;
          end else if (phase_q == PH_W2) begin
            phase_d = PH_NUM_PRE;
            priority if (ended[KW_MIN]) begin
              kind_d = KIND_SET_MIN;
              opt_d  = 1'b1;
            end else if (ended[KW_MAX]) begin
              kind_d = KIND_SET_MAX;
              opt_d  = 1'b1;
            end else if (ended[KW_CURVE]) begin
              phase_d = PH_W3_PRE;
            end else if (ended[KW_GAMMA]) begin
              kind_d = KIND_GAMMA;
              real_d = 1'b1;
            end else if (ended[KW_ALPHA]) begin
              kind_d = KIND_ALPHA;
              real_d = 1'b1;
            end else begin
              phase_d = PH_FAIL;
            end
          end else begin
            phase_d = PH_NUM_PRE;
            kind_d  = KIND_CURVE;
            real_d  = 1'b1;
            opt_d   = 1'b1;
            priority if (ended[KW_LINEAR]) curve_d = CURVE_LINEAR;
            else if (ended[KW_POWER])      curve_d = CURVE_POWER;
            else if (ended[KW_SCURVE])     curve_d = CURVE_SCURVE;
            else begin
              phase_d = PH_FAIL;
              kind_d  = KIND_UNKNOWN;
            end
          end
        end
        PH_NUM_PRE: begin
          priority if (is_numspace(c)) begin
            if (!blank) prenb_d = 1'b1;
          end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            neg_d   = c == CHAR_MINUS;
            phase_d = PH_NUM_INT;
          end else if (is_digit(c)) begin
            acc_d   = acc_digit;
            dig_d   = 1'b1;
            phase_d = PH_NUM_INT;
          end else if (c == CHAR_DOT && real_q) begin
            phase_d = PH_NUM_FRAC;
          end else begin
            phase_d = PH_FAIL;
          end
        end
        PH_NUM_INT: begin
          priority if (is_digit(c)) begin
            acc_d = acc_digit;
            dig_d = 1'b1;
          end else if (c == CHAR_DOT && real_q) begin
            phase_d = PH_NUM_FRAC;
          end else if (blank && dig_q) begin
            phase_d = PH_NUM_TRAIL;
          end else begin
            phase_d = PH_FAIL;
          end
        end
        PH_NUM_FRAC: begin
          priority if (is_digit(c)) begin
            dig_d = 1'b1;
            if (nf_q != 2'd3) begin
              frac_d = frac_q + frac_add;
              nf_d   = nf_q + 2'd1;
            end
          end else if (blank && dig_q) begin
            phase_d = PH_NUM_TRAIL;
          end else begin
            phase_d = PH_FAIL;
          end
        end
        PH_NUM_TRAIL: begin
          if (!blank) phase_d = PH_FAIL;
        end
        PH_DONE, PH_FAIL: begin
          phase_d = phase_q;
        end
        default: phase_d = PH_FAIL;
      endcase
    end
  end

  always_comb begin
    fin_ok    = (phase_d == PH_DONE) || (phase_d == PH_NUM_TRAIL) ||
                ((phase_d == PH_NUM_PRE) && opt_d && !prenb_d);
    fin_int   = (!real_d && dig_d) ? apply_sign(acc_d, neg_d) : '0;
    fin_real  = (real_d && dig_d) ? apply_sign(acc_d + 32'(frac_d), neg_d) : '0;
    stream_ok = (kind_d != KIND_STREAM) || (fin_int == 32'd0) || (fin_int == 32'd1);
    fin_kind  = (fin_ok && stream_ok) ? kind_d : KIND_UNKNOWN;
    fin_has_int    = fin_ok && dig_d && (kind_d == KIND_SET_MIN || kind_d == KIND_SET_MAX);
    fin_gamma_flag = fin_ok && dig_d && (kind_d == KIND_CURVE);
    fin_empty      = phase_d == PH_W1_PRE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_W1_PRE;
      cand_q      <= '1;
      pos_q       <= '0;
      kind_q      <= KIND_UNKNOWN;
      curve_q     <= CURVE_LINEAR;
      real_q      <= 1'b0;
      opt_q       <= 1'b0;
      prenb_q     <= 1'b0;
      neg_q       <= 1'b0;
      dig_q       <= 1'b0;
      acc_q       <= '0;
      frac_q      <= '0;
      nf_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (line_end) begin
        phase_q          <= PH_W1_PRE;
        cand_q           <= '1;
        pos_q            <= '0;
        kind_q           <= KIND_UNKNOWN;
        curve_q          <= CURVE_LINEAR;
        real_q           <= 1'b0;
        opt_q            <= 1'b0;
        prenb_q          <= 1'b0;
        neg_q            <= 1'b0;
        dig_q            <= 1'b0;
        acc_q            <= '0;
        frac_q           <= '0;
        nf_q             <= '0;
        out_valid_q      <= 1'b1;
        out_kind_q       <= fin_kind;
        out_has_int_q    <= fin_has_int;
        out_int_q        <= fin_int;
        out_curve_q      <= curve_d;
        out_gamma_flag_q <= fin_gamma_flag;
        out_real_q       <= fin_real;
        out_ovf_q        <= q_word_i.ovf;
        out_empty_q      <= fin_empty;
      end else begin
        phase_q <= phase_d;
        cand_q  <= cand_d;
        pos_q   <= pos_d;
        kind_q  <= kind_d;
        curve_q <= curve_d;
        real_q  <= real_d;
        opt_q   <= opt_d;
        prenb_q <= prenb_d;
        neg_q   <= neg_d;
        dig_q   <= dig_d;
        acc_q   <= acc_d;
        frac_q  <= frac_d;
        nf_q    <= nf_d;
        if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_kind_q;
  assign has_int_arg_o    = out_has_int_q;
  assign int_arg_o        = out_int_q;
  assign curve_sel_o      = out_curve_q;
  assign has_gamma_arg_o  = out_gamma_flag_q;
  assign real_arg_milli_o = out_real_q;
  assign line_overflow_o  = out_ovf_q;
  assign line_empty_o     = out_empty_q;

endmodule

`default_nettype wire

// ----- rtl/core/tcld_checker.sv -----
// ----------------------------------------------------------------------------
// tcld_checker
// Port-level checks of the command line decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tcld_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid_i,
  input wire               in_stall_o,
  input wire [7:0]         char_byte_i,
  input wire               out_valid_o,
  input wire               out_stall_i,
  input wire [3:0]         kind_o,
  input wire               has_int_arg_o,
  input wire signed [31:0] int_arg_o,
  input wire [1:0]         curve_sel_o,
  input wire               has_gamma_arg_o,
  input wire signed [31:0] real_arg_milli_o,
  input wire               line_overflow_o,
  input wire               line_empty_o
);
  import tcld_pkg::*;

  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(int_arg_o) && $stable(real_arg_milli_o), "stalled result changed")
  `ASSERT_IMPLY(a_empty_no_cmd, clk_i, rst_ni, out_valid_o && line_empty_o, kind_o == KIND_UNKNOWN && !has_int_arg_o && !has_gamma_arg_o, "empty line gave a command")
  `ASSERT_IMPLY(a_int_kind, clk_i, rst_ni, out_valid_o && has_int_arg_o, kind_o == KIND_SET_MIN || kind_o == KIND_SET_MAX, "integer flag on wrong kind")
  `ASSERT_IMPLY(a_gamma_kind, clk_i, rst_ni, out_valid_o && has_gamma_arg_o, kind_o == KIND_CURVE, "gamma flag on wrong kind")
  `ASSERT_IMPLY(a_stream_val, clk_i, rst_ni, out_valid_o && kind_o == KIND_STREAM, int_arg_o == 32'sd0 || int_arg_o == 32'sd1, "stream value out of range")

endmodule

bind text_command_line_decoder tcld_checker u_tcld_checker (.*);

`default_nettype wire

// ----- tb/sv/text_command_line_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// text_command_line_decoder_tb
// Streams command lines into the decoder one character word at a time, with
// random gaps and output stalls. A built-in line decoder predicts each
// result on newline, and every result is compared field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

import tcld_pkg::*;

typedef struct {
  kind_e       kind;
  bit          has_int;
  logic [31:0] int_val;
  curve_e      curve;
  bit          gamma_flag;
  logic [31:0] milli;
  bit          ovf;
  bit          empty;
} line_result_t;

class line_scoreboard;
  byte unsigned line_q[LINE_LEN];
  int unsigned  count;
  int unsigned  eff;
  bit           ovf;
  line_result_t pending_q[$];
  int           errors;

  function new();
    count = 0;
    ovf = 0;
    eff = 0;
    errors = 0;
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function int unsigned at(int unsigned i);
    if (i < eff && i < LINE_LEN) return line_q[i];
    return 0;
  endfunction

  function bit blank(int unsigned c);
    return c == 32 || c == 9;
  endfunction

  function bit digit(int unsigned c);
    return c >= 48 && c <= 57;
  endfunction

  function int unsigned skip_blank(int unsigned i);
    while (i < LINE_LEN && blank(at(i))) i++;
    return i;
  endfunction

  function int unsigned skip_num(int unsigned i);
    while (i < LINE_LEN && (at(i) == 32 || (at(i) >= 9 && at(i) <= 13))) i++;
    return i;
  endfunction

  function int unsigned word_len(int unsigned i);
    int unsigned n;
    n = 0;
    while (i + n < LINE_LEN && at(i + n) != 0 && !blank(at(i + n))) n++;
    return n;
  endfunction

  function bit word_is(int unsigned i, int unsigned n, string kw);
    int unsigned a;
    if (n != kw.len()) return 0;
    for (int unsigned k = 0; k < n; k++) begin
      a = at(i + k);
      if (a >= 97 && a <= 122) a -= 32;
      if (a != kw[k]) return 0;
    end
    return 1;
  endfunction

  function bit ends_here(int unsigned i);
    return at(skip_blank(i)) == 0;
  endfunction

  function logic [31:0] signed_sat(longint unsigned mag, bit neg);
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return 32'(32'd0 - 32'(mag));
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return 32'(mag);
  endfunction

  function bit read_int(int unsigned i, output logic [31:0] val, output int unsigned fin);
    longint unsigned mag;
    bit neg, any;
    mag = 0; neg = 0; any = 0;
    i = skip_num(i);
    if (at(i) == 43 || at(i) == 45) begin
      neg = at(i) == 45;
      i++;
    end
    while (i < LINE_LEN && digit(at(i))) begin
      mag = mag * 10 + (at(i) - 48);
      if (mag > 64'h8000_0000) mag = 64'h8000_0001;
      any = 1;
      i++;
    end
    if (!any) return 0;
    val = signed_sat(mag, neg);
    fin = i;
    return 1;
  endfunction

  function bit read_real(int unsigned i, output logic [31:0] val, output int unsigned fin);
    longint unsigned ip, fr;
    int unsigned nf, j;
    bit neg, any, fany;
    ip = 0; fr = 0; nf = 0; neg = 0; any = 0;
    i = skip_num(i);
    if (at(i) == 43 || at(i) == 45) begin
      neg = at(i) == 45;
      i++;
    end
    while (i < LINE_LEN && digit(at(i))) begin
      ip = ip * 10 + (at(i) - 48);
      if (ip > 3000000) ip = 3000000;
      any = 1;
      i++;
    end
    if (at(i) == 46) begin
      j = i + 1;
      fany = 0;
      while (j < LINE_LEN && digit(at(j))) begin
        if (nf < 3) begin
          fr = fr * 10 + (at(j) - 48);
          nf++;
        end
        fany = 1;
        j++;
      end
      if (any || fany) begin
        any = 1;
        i = j;
      end
    end
    if (!any) return 0;
    while (nf < 3) begin
      fr *= 10;
      nf++;
    end
    val = signed_sat(ip * 1000 + fr, neg);
    fin = i;
    return 1;
  endfunction

  function void decode_line(ref line_result_t r);
    int unsigned p, n, rest, fin, m;
    logic [31:0] v;
    p = skip_blank(0);
    if (at(p) == 0) begin
      r.empty = 1;
      return;
    end
    n = word_len(p);
    if (word_is(p, n, "PING"))  begin r.kind = KIND_PING;  return; end
    if (word_is(p, n, "GET"))   begin r.kind = KIND_GET;   return; end
    if (word_is(p, n, "SAVE"))  begin r.kind = KIND_SAVE;  return; end
    if (word_is(p, n, "LOAD"))  begin r.kind = KIND_LOAD;  return; end
    if (word_is(p, n, "RESET")) begin r.kind = KIND_RESET; return; end
    if (word_is(p, n, "STREAM")) begin
      rest = skip_blank(p + n);
      if (read_int(rest, v, fin)) begin
        r.int_val = v;
        if (ends_here(fin) && v <= 1) r.kind = KIND_STREAM;
      end
      return;
    end
    if (!word_is(p, n, "SET")) return;
    p = skip_blank(p + n);
    n = word_len(p);
    if (word_is(p, n, "MIN") || word_is(p, n, "MAX")) begin
      rest = skip_blank(p + n);
      if (at(rest) == 0) begin
        r.kind = word_is(p, n, "MIN") ? KIND_SET_MIN : KIND_SET_MAX;
        return;
      end
      if (read_int(rest, v, fin)) begin
        r.int_val = v;
        if (ends_here(fin)) begin
          r.kind = word_is(p, n, "MIN") ? KIND_SET_MIN : KIND_SET_MAX;
          r.has_int = 1;
        end
      end
      return;
    end
    if (word_is(p, n, "CURVE")) begin
      rest = skip_blank(p + n);
      m = word_len(rest);
      if (word_is(rest, m, "LINEAR")) r.curve = CURVE_LINEAR;
      else if (word_is(rest, m, "POWER")) r.curve = CURVE_POWER;
      else if (word_is(rest, m, "SCURVE")) r.curve = CURVE_SCURVE;
      else return;
      rest = skip_blank(rest + m);
      if (at(rest) == 0) begin
        r.kind = KIND_CURVE;
        return;
      end
      if (read_real(rest, v, fin)) begin
        r.milli = v;
        if (ends_here(fin)) begin
          r.kind = KIND_CURVE;
          r.gamma_flag = 1;
        end
      end
      return;
    end
    if (word_is(p, n, "GAMMA") || word_is(p, n, "ALPHA")) begin
      rest = skip_blank(p + n);
      if (read_real(rest, v, fin)) begin
        r.milli = v;
        if (ends_here(fin)) r.kind = word_is(p, n, "GAMMA") ? KIND_GAMMA : KIND_ALPHA;
      end
    end
  endfunction

  function void note_char(byte unsigned c);
    line_result_t r;
    if (c == CHAR_CR) return;
    if (c != CHAR_LF) begin
      if (count + 1 >= LINE_LEN) ovf = 1;
      else begin
        line_q[count] = c;
        count++;
      end
      return;
    end
    eff = 0;
    while (eff < count && line_q[eff] != 0) eff++;
    r = '{KIND_UNKNOWN, 0, '0, CURVE_LINEAR, 0, '0, 0, 0};
    decode_line(r);
    r.ovf = ovf;
    pending_q.push_back(r);
    count = 0;
    ovf = 0;
    eff = 0;
  endfunction

  task check_result(line_result_t got);
    line_result_t exp_r;
    if (pending_q.size() == 0) begin
      report("result with no line pending");
      return;
    end
    exp_r = pending_q.pop_front();
    if (got.kind != exp_r.kind)
      report($sformatf("kind %0d, want %0d", got.kind, exp_r.kind));
    if (got.has_int != exp_r.has_int)
      report($sformatf("has_int_arg %0d, want %0d", got.has_int, exp_r.has_int));
    if (got.int_val !== exp_r.int_val)
      report($sformatf("int_arg %h, want %h", got.int_val, exp_r.int_val));
    if (got.curve != exp_r.curve)
      report($sformatf("curve_sel %0d, want %0d", got.curve, exp_r.curve));
    if (got.gamma_flag != exp_r.gamma_flag)
      report($sformatf("gamma flag %0d, want %0d", got.gamma_flag, exp_r.gamma_flag));
    if (got.milli !== exp_r.milli)
      report($sformatf("real_arg_milli %h, want %h", got.milli, exp_r.milli));
    if (got.ovf != exp_r.ovf)
      report($sformatf("line_overflow %0d, want %0d", got.ovf, exp_r.ovf));
    if (got.empty != exp_r.empty)
      report($sformatf("line_empty %0d, want %0d", got.empty, exp_r.empty));
  endtask
endclass

module text_command_line_decoder_tb;
  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  char_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  kind_o;
  logic        has_int_arg_o;
  logic [31:0] int_arg_o;
  logic [1:0]  curve_sel_o;
  logic        has_gamma_arg_o;
  logic [31:0] real_arg_milli_o;
  logic        line_overflow_o;
  logic        line_empty_o;

  line_scoreboard line_sb;
  logic           word_taken;
  bit             quiet;
  int             words_sent;

  text_command_line_decoder dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .char_byte_i,
    .out_valid_o, .out_stall_i, .kind_o, .has_int_arg_o, .int_arg_o,
    .curve_sel_o, .has_gamma_arg_o, .real_arg_milli_o,
    .line_overflow_o, .line_empty_o
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_taken <= 0;
    end else begin
      word_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) line_sb.note_char(char_byte_i);
      if (out_valid_o && !out_stall_i)
        line_sb.check_result('{kind_e'(kind_o), has_int_arg_o, int_arg_o,
                               curve_e'(curve_sel_o), has_gamma_arg_o,
                               real_arg_milli_o, line_overflow_o, line_empty_o});
    end
  end

  always @(negedge clk_i) begin
    out_stall_i = quiet ? 1'b0 : ($urandom_range(99) < 15);
  end

  task send_word(byte unsigned c);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid_i = 0;
      char_byte_i = 8'($urandom);
      @(negedge clk_i);
    end
    in_valid_i = 1;
    char_byte_i = c;
    do @(negedge clk_i); while (!word_taken);
    in_valid_i = 0;
    words_sent++;
  endtask

  task send_line(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i]);
    send_word(CHAR_LF);
  endtask

  task send_noise();
    int n;
    byte unsigned c;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      do c = 8'($urandom); while (c == CHAR_LF);
      send_word(c);
    end
    send_word(CHAR_LF);
  endtask

  function string mixcase(string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++)
      if (r[i] >= "A" && r[i] <= "Z" && $urandom_range(1)) r[i] = r[i] + 8'd32;
    return r;
  endfunction

  function string gap();
    string r;
    r = "";
    repeat ($urandom_range(1, 2)) r = {r, $urandom_range(3) == 0 ? "\t" : " "};
    return r;
  endfunction

  function string digits(int n);
    string r;
    r = "";
    repeat (n) r = {r, $sformatf("%0d", $urandom_range(9))};
    return r;
  endfunction

  function string sign_str();
    case ($urandom_range(3))
      0: return "-";
      1: return "+";
      default: return "";
    endcase
  endfunction

  function string int_str();
    int n;
    n = $urandom_range(4) == 0 ? $urandom_range(9, 13) : $urandom_range(1, 4);
    return {sign_str(), digits(n)};
  endfunction

  function string real_str();
    string r;
    r = {sign_str(), digits($urandom_range(5) == 0 ? $urandom_range(6, 9) : $urandom_range(0, 2))};
    if ($urandom_range(2) != 0) r = {r, ".", digits($urandom_range(0, 5))};
    return r;
  endfunction

  function string tail();
    case ($urandom_range(9))
      0: return " x";
      1: return "e3";
      2: return gap();
      default: return "";
    endcase
  endfunction

  function string gen_line();
    string s, names[3];
    names = '{"LINEAR", "POWER", "SCURVE"};
    case ($urandom_range(11))
      0: s = {mixcase("PING"), $urandom_range(1) ? {gap(), "abc"} : ""};
      1: s = mixcase($urandom_range(1) ? "GET" : "SAVE");
      2: s = mixcase($urandom_range(1) ? "LOAD" : "RESET");
      3: s = {mixcase("STREAM"), gap(), $urandom_range(3) == 0 ? int_str()
              : $sformatf("%0d", $urandom_range(1)), tail()};
      4, 5: s = {mixcase("SET"), gap(), mixcase($urandom_range(1) ? "MIN" : "MAX"),
                 $urandom_range(4) == 0 ? "" : {gap(), int_str(), tail()}};
      6, 7: s = {mixcase("SET"), gap(), mixcase("CURVE"), gap(),
                 $urandom_range(7) == 0 ? "CUBIC" : mixcase(names[$urandom_range(2)]),
                 $urandom_range(2) == 0 ? "" : {gap(), real_str(), tail()}};
      8, 9: s = {mixcase("SET"), gap(), mixcase($urandom_range(1) ? "GAMMA" : "ALPHA"),
                 gap(), real_str(), tail()};
      10: s = $urandom_range(1) ? gap() : "SET FOO 1";
      default: s = {"PIN", "\r", "G"};
    endcase
    if ($urandom_range(3) == 0) s = {gap(), s};
    if ($urandom_range(9) == 0) s = {s, "\r"};
    return s;
  endfunction

  initial begin
    string directed[$];
    line_sb = new();
    rst_ni = 0;
    in_valid_i = 0;
    char_byte_i = '0;
    out_stall_i = 0;
    quiet = 0;
    words_sent = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    directed = '{"PING", "get extra", "Save", "LOAD", "reset", "STREAM 0", "stream\t1",
                 "STREAM 2", "SET MIN", "SET MAX -2147483649", "set min 99999999999",
                 "SET CURVE LINEAR", "SET CURVE power 2.5", "set curve scurve -.1239",
                 "SET GAMMA 3000001", "SET ALPHA +1.", "SET ALPHA .", "SET MIN 5 x",
                 "  \t", "", "SET\tMAX\t+2147483647", "SET GAMMA \v7.25"};
    foreach (directed[i]) send_line(directed[i]);
    send_line({"PING ", digits(70)});
    send_word("P"); send_word(8'd0); send_word("I"); send_word(CHAR_LF);
    send_word(8'd255); send_word(CHAR_CR); send_word(CHAR_LF);

    while (words_sent < 1800) begin
      quiet = words_sent > 700 && words_sent < 1000;
      case ($urandom_range(19))
        0: send_noise();
        1: send_line({"SET MIN ", digits($urandom_range(50, 80))});
        default: send_line(gen_line());
      endcase
    end
    quiet = 0;

    while (line_sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (line_sb.errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/tcld_pkg.sv
rtl/core/tcld_front.sv
rtl/core/tcld_queue.sv
rtl/core/tcld_back.sv
rtl/core/text_command_line_decoder.sv
rtl/core/tcld_checker.sv
tb/sv/text_command_line_decoder_tb.sv
